>>> sv/aesd_pkg.sv
package aesd_pkg;

  localparam int NUM_ROUNDS_DEF = 10;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 8'd1;

  typedef enum logic [2:0] {
    ST_RESET,
    ST_EXPAND,
    ST_IDLE,
    ST_KEYADD,
    ST_ROUND,
    ST_DONE
  } state_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] gfm(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gfm = p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gfm(r, b);
      b = gfm(b, b);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rl(input logic [7:0] x, input int n);
    rl = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_f(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    sbox_f = b ^ rl(b, 1) ^ rl(b, 2) ^ rl(b, 3) ^ rl(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] isbox_f(input logic [7:0] x);
    isbox_f = ginv(rl(x, 1) ^ rl(x, 3) ^ rl(x, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] tab_t [256];

  function automatic tab_t mk_sbox();
    tab_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox_f(8'(i));
    return t;
  endfunction

  function automatic tab_t mk_isbox();
    tab_t t;
    for (int i = 0; i < 256; i++) t[i] = isbox_f(8'(i));
    return t;
  endfunction

  localparam tab_t SBOX = mk_sbox();
  localparam tab_t ISBOX = mk_isbox();

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    r = 8'h01;
    for (int k = 0; k < 10; k++) begin
      if (4'(k) < i) r = xt(r);
    end
    rcon = r;
  endfunction

endpackage

>>> sv/aesd_if.sv
interface aesd_data_if;
  logic        valid;
  logic        ready;
  logic [63:0] upper;
  logic [63:0] lower;
  modport source(output valid, output upper, output lower, input ready);
  modport sink(input valid, input upper, input lower, output ready);
endinterface

interface aesd_cfg_if;
  import aesd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> sv/aes128_block_decrypt.sv
// An accepted item passes through the key add, ten inverse rounds and the output load
// before its result is valid.
// No new item is accepted until the current result is loaded; each round reads one 128-bit
// round key from the round key memory, which has a registered read. A result that waits
// holds the next item in its output state until the waiting one is taken.
// Reset: key is zero; the zero key is loaded and expanded, and no item is accepted during
// the expansion. Every key write starts a new expansion.
module aes128_block_decrypt
  import aesd_pkg::*;
#(
  parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
  input logic clk,
  input logic rst,
  aesd_data_if.sink   cipher,
  aesd_data_if.source plain,
  aesd_cfg_if.sink    cfg
);

  localparam int RW = $clog2(NUM_ROUNDS + 1);

  state_t state, state_next;
  logic [127:0] rk_mem [NUM_ROUNDS + 1];
  logic [127:0] rk_rd;
  logic [RW-1:0] rd_addr;
  logic [127:0] key;
  logic [127:0] wk;
  logic [RW-1:0] cnt;
  logic [127:0] st;
  logic [127:0] out_q;
  logic out_valid;
  logic in_fire, cfg_fire, key_wr;

  assign cfg.ready = 1'b1;
  assign cfg_fire = cfg.valid;
  assign key_wr = cfg_fire && (cfg.index == REG_KEY_UPPER || cfg.index == REG_KEY_LOWER);
  assign cipher.ready = (state == ST_IDLE);
  assign in_fire = cipher.valid && cipher.ready;
  assign plain.valid = out_valid;
  assign plain.upper = out_q[127:64];
  assign plain.lower = out_q[63:0];

  function automatic logic [127:0] next_rk(input logic [127:0] w, input logic [RW-1:0] i);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t = {SBOX[w[23:16]] ^ rcon(4'(i)), SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    w0 = w[127:96] ^ t;
    w1 = w[95:64] ^ w0;
    w2 = w[63:32] ^ w1;
    w3 = w[31:0] ^ w2;
    next_rk = {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic mix);
    logic [7:0] a [16];
    logic [7:0] t [16];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) a[i] = s[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int q = 0; q < 4; q++) begin
        t[q + 4*c] = ISBOX[a[q + 4*((c - q) & 3)]] ^ k[127 - 8*(q + 4*c) -: 8];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a[4*c]   = gmul(t[4*c], 4'd14) ^ gmul(t[4*c+1], 4'd11) ^
                   gmul(t[4*c+2], 4'd13) ^ gmul(t[4*c+3], 4'd9);
        a[4*c+1] = gmul(t[4*c], 4'd9) ^ gmul(t[4*c+1], 4'd14) ^
                   gmul(t[4*c+2], 4'd11) ^ gmul(t[4*c+3], 4'd13);
        a[4*c+2] = gmul(t[4*c], 4'd13) ^ gmul(t[4*c+1], 4'd9) ^
                   gmul(t[4*c+2], 4'd14) ^ gmul(t[4*c+3], 4'd11);
        a[4*c+3] = gmul(t[4*c], 4'd11) ^ gmul(t[4*c+1], 4'd13) ^
                   gmul(t[4*c+2], 4'd9) ^ gmul(t[4*c+3], 4'd14);
      end
    end else begin
      for (int i = 0; i < 16; i++) a[i] = t[i];
    end
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = a[i];
    inv_round = r;
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      ST_RESET:  state_next = ST_EXPAND;
      ST_EXPAND: if (cnt == RW'(NUM_ROUNDS)) state_next = ST_IDLE;
      ST_IDLE:   if (in_fire) state_next = ST_KEYADD;
      ST_KEYADD: state_next = ST_ROUND;
      ST_ROUND:  if (cnt == RW'(0)) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || plain.ready) state_next = ST_IDLE;
      default:   state_next = ST_RESET;
    endcase
    if (key_wr) state_next = ST_RESET;
  end

  always_comb begin
    rd_addr = RW'(NUM_ROUNDS);
    if (state == ST_KEYADD || (state == ST_ROUND && cnt != RW'(0))) rd_addr = cnt - RW'(1);
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXPAND) rk_mem[cnt] <= wk;
    rk_rd <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RESET;
      key <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire && cfg.index == REG_KEY_UPPER) key[127:64] <= cfg.data;
      if (cfg_fire && cfg.index == REG_KEY_LOWER) key[63:0] <= cfg.data;
      if (state == ST_DONE && (!out_valid || plain.ready)) begin
        out_q <= st;
        out_valid <= 1'b1;
      end else if (plain.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_RESET: begin
          cnt <= '0;
          wk <= key;
        end
        ST_EXPAND: begin
          cnt <= cnt + RW'(1);
          wk <= next_rk(wk, cnt);
        end
        ST_IDLE: begin
          st <= {cipher.upper, cipher.lower};
          cnt <= RW'(NUM_ROUNDS);
        end
        ST_KEYADD: begin
          st <= st ^ rk_rd;
          cnt <= cnt - RW'(1);
        end
        ST_ROUND: begin
          st <= inv_round(st, rk_rd, cnt != RW'(0));
          if (cnt != RW'(0)) cnt <= cnt - RW'(1);
        end
        default: cnt <= '0;
      endcase
    end
  end

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == ST_IDLE)
    else $error("item accepted while busy");
  ap_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !key_wr |=> out_valid)
    else $error("result not presented");
  ap_expand_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXPAND && !key_wr |=> cnt == $past(cnt) + RW'(1))
    else $error("expansion counter slipped");

endmodule
